### rtl/pcrf_pkg.sv
`timescale 1ns / 1ps
// Package for the parent chain root finder: item types, link type and codes.
package pcrf_pkg;

    localparam int ID_W  = 16;   // identifier field width on the ports
    localparam int SLOT_W = 4;   // slot field width on the ports
    localparam int HOP_W = 5;    // hop_count field width on the ports

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        logic              entry_valid;
        logic [ID_W-1:0]   entry_id;
        logic              entry_has_parent;
        logic [ID_W-1:0]   entry_parent;
        logic [ID_W-1:0]   query_id;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]  root_id;
        logic             start_found;
        logic             walk_cut;
        logic [HOP_W-1:0] hop_count;
    } t_out_item;

    // Result of the priority search, rippled from cell to cell.
    typedef struct packed {
        logic            hit;
        logic            has_parent;
        logic [ID_W-1:0] parent;
    } t_link;

endpackage

### rtl/pcrf_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input and result items.
interface pcrf_in_if import pcrf_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pcrf_out_if import pcrf_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/parent_chain_root_finder.sv
`timescale 1ns / 1ps
// Top level of the parent chain root finder: cell row, walk control, result register.
//
// The table is a row of ENTRIES cells, one slot each; the identifier being
// looked up is broadcast to all cells and the lowest live match ripples up
// the row, so each lookup (start or hop) is combinational. A write item
// gives no result. A query item looks up its start identifier, then each of
// the h parent links followed (0 to ENTRIES), then returns to idle; its last
// step waits while the output register is full. Items are taken only while
// no query is walking; writes are still taken while a result waits in the
// output register. Identifiers are kept to ID_BITS bits, at most ID_W. A
// start identifier not in the table comes back as its own root with
// start_found low; a parent identifier not in the table is taken as the root;
// after ENTRIES hops the walk stops, walk_cut high if that entry has a parent.
// The live bits clear on reset; no clearing pass is needed.
module parent_chain_root_finder import pcrf_pkg::*; #(
    parameter int ENTRIES = 16,
    parameter int ID_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pcrf_in_if.sink       i_in,
    pcrf_out_if.source    o_out
);

    localparam int SW   = (ID_BITS < ID_W) ? ID_BITS : ID_W; // stored id width
    localparam int CNTW = $clog2(ENTRIES + 1);               // hop counter width

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    t_state          r_state, n_state;
    logic [SW-1:0]   r_id;
    logic [CNTW-1:0] r_hops;
    logic            r_first;
    logic            r_found;
    logic            r_out_valid;
    t_out_item       r_out_data;

    t_link           w_link [ENTRIES+1];
    logic            w_in_fire;
    logic            w_wr_fire;
    logic            w_out_free;
    logic            w_found;
    logic            w_limit;
    logic            w_cut;
    logic            w_fin;

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign w_wr_fire   = w_in_fire && (i_in.data.kind == KIND_WRITE);
    assign w_out_free  = !r_out_valid || o_out.ready;

    // Cell row; the search enters at slot 0.
    assign w_link[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        pcrf_cell #(
            .W (SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_we    (w_wr_fire && (32'(i_in.data.slot) == g)),
            .i_wr    (i_in.data),
            .i_key   (r_id),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1])
        );
    end

    // One step of the walk on the search result for r_id.
    assign w_found = r_first ? w_link[ENTRIES].hit : r_found;
    assign w_limit = (r_hops == CNTW'(ENTRIES));
    assign w_cut   = w_link[ENTRIES].hit && w_link[ENTRIES].has_parent && w_limit;
    assign w_fin   = !w_link[ENTRIES].hit || !w_link[ENTRIES].has_parent || w_limit;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire && (i_in.data.kind == KIND_QUERY)) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (w_fin && w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Walk registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_id    <= i_in.data.query_id[SW-1:0];
            r_hops  <= '0;
            r_first <= 1'b1;
            r_found <= 1'b0;
        end else if (!w_fin) begin
            r_id    <= w_link[ENTRIES].parent[SW-1:0];
            r_hops  <= r_hops + 1'b1;
            r_first <= 1'b0;
            r_found <= w_found;
        end
    end

    // Result register; a finished walk waits here until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_WALK) && w_fin && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_WALK) && w_fin && w_out_free) begin
            r_out_data.root_id     <= ID_W'(r_id);
            r_out_data.start_found <= w_found;
            r_out_data.walk_cut    <= w_cut;
            r_out_data.hop_count   <= HOP_W'(r_hops);
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

endmodule

### rtl/pcrf_cell.sv
`timescale 1ns / 1ps
// One table slot: holds an entry and takes part in the priority search chain.
module pcrf_cell import pcrf_pkg::*; #(
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_we,
    input  t_in_item     i_wr,
    input  logic [W-1:0] i_key,
    input  t_link        i_link,
    output t_link        o_link
);

    logic         r_live;
    logic [W-1:0] r_ident;
    logic         r_has_parent;
    logic [W-1:0] r_parent;
    logic         w_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else if (i_we) begin
            r_live <= i_wr.entry_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_ident      <= i_wr.entry_id[W-1:0];
            r_has_parent <= i_wr.entry_has_parent;
            r_parent     <= i_wr.entry_parent[W-1:0];
        end
    end

    assign w_match = r_live && (r_ident == i_key);

    // Lower slot already hit: pass its answer on unchanged.
    always_comb begin
        o_link = i_link;
        if (!i_link.hit && w_match) begin
            o_link.hit        = 1'b1;
            o_link.has_parent = r_has_parent;
            o_link.parent     = ID_W'(r_parent);
        end
    end

endmodule
